FILE: rtl/nnc_pkg.sv
// Shared types and constants for the nearest-neighbour classifier.
// No dependencies; every other file in rtl imports this package.
`default_nettype none

package nnc_pkg;

  localparam int MAX_SAMPLES = 64;
  localparam int MAX_DIMS    = 4;

  localparam int NUM_FEAT = 4;
  localparam int FEAT_W   = 16;
  localparam int CLASS_W  = 8;
  localparam int KIND_W   = 2;
  localparam int CFG_W    = 3;
  localparam int DIST_W   = 17;

  localparam logic [CFG_W-1:0] DIMS_RESET = 3'd2;

  localparam int IDX_W  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int MAG_W  = FEAT_W;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = 2 * DIST_W;
  localparam int MEM_W  = NUM_FEAT * FEAT_W + CLASS_W;
  localparam int STEP_W = $clog2(DIST_W);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                             kind;
    logic [NUM_FEAT-1:0][FEAT_W-1:0]   features;
    logic [CLASS_W-1:0]                class_id;
  } item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_SQRT
  } back_state_t;

endpackage

`default_nettype wire

FILE: rtl/nnc_sqrt.sv
// Iterative floor square root, one result bit per cycle.
// Depends on nnc_pkg for widths.
`default_nettype none

module nnc_sqrt (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [nnc_pkg::SUM_W-1:0] radicand,
  output logic                           done,
  output logic [nnc_pkg::DIST_W-1:0]     root
);
  import nnc_pkg::*;

  logic                run_r, run_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [SUM_W-1:0]    rad_r, rad_nxt;
  logic [DIST_W+2:0]   rem_r, rem_nxt;
  logic [DIST_W-1:0]   root_r, root_nxt;
  logic [DIST_W+2:0]   rem_sh;
  logic [DIST_W+2:0]   trial;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    // The remainder never exceeds twice the partial root, so its low bits suffice.
    rem_sh   = {rem_r[DIST_W:0], rad_r[SUM_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    if (start) begin
      run_nxt  = 1'b1;
      step_nxt = STEP_W'(DIST_W - 1);
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (run_r) begin
      rad_nxt = {rad_r[SUM_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[DIST_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[DIST_W-2:0], 1'b0};
      end
      step_nxt = step_r - 1'b1;
      if (step_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

FILE: rtl/nnc_front.sv
// Front end: takes command transactions, drops unknown kinds and queues the rest.
// Depends on nnc_pkg for the item type and queue depth.
`default_nettype none

module nnc_front (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire nnc_pkg::item_t         in_item,
  input  wire logic [nnc_pkg::KIND_W-1:0] in_kind_raw,
  output logic                        busy,
  output logic                        q_valid,
  output nnc_pkg::item_t              q_item,
  input  wire logic                   q_pop
);
  import nnc_pkg::*;

  item_t             q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              accept;
  logic              push;
  logic              pop;
  logic              kind_ok;

  always_comb begin
    unique case (in_kind_raw) inside
      KIND_LOAD, KIND_QUERY, KIND_CLEAR: kind_ok = 1'b1;
      default:                           kind_ok = 1'b0;
    endcase
  end

  assign busy    = (cnt_r == QCNT_W'(QDEPTH));
  assign accept  = start && !busy;
  assign push    = accept && kind_ok;
  assign q_valid = (cnt_r != '0);
  assign pop     = q_pop && q_valid;
  assign q_item  = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= in_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/nnc_back.sv
// Back end: sample store, distance scan pipeline, square root and result register.
// Depends on nnc_pkg and nnc_sqrt.
`default_nettype none

module nnc_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [nnc_pkg::CFG_W-1:0]   cfg_wdata,
  input  wire logic                        q_valid,
  input  wire nnc_pkg::item_t              q_item,
  output logic                             q_pop,
  output logic                             out_valid,
  output logic                             out_found,
  output logic [nnc_pkg::CLASS_W-1:0]      out_class_out,
  output logic [nnc_pkg::DIST_W-1:0]       out_distance,
  output logic                             out_loads_dropped
);
  import nnc_pkg::*;

  logic [MEM_W-1:0] mem [MAX_SAMPLES];

  back_state_t state_r, state_nxt;
  logic [CFG_W-1:0] dims_r;
  logic [CFG_W-1:0] dims_eff;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] issue_r, issue_nxt;
  logic             mem_we;
  logic             rd_en;
  logic             query_start;
  logic             sqrt_start;
  logic             sqrt_done;
  logic [DIST_W-1:0] sqrt_root;
  logic             pipe_busy;

  logic [NUM_FEAT-1:0][FEAT_W-1:0] qf_r;

  logic [MEM_W-1:0]                rd_data_r;
  logic                            v_rd_r, v_mag_r, v_sq_r, v_sum_r;
  logic [NUM_FEAT-1:0][MAG_W-1:0]  mag_r;
  logic [NUM_FEAT-1:0][SQ_W-1:0]   sq_r;
  logic [SUM_W-1:0]                sum_r;
  logic [CLASS_W-1:0]              cls_mag_r, cls_sq_r, cls_sum_r;
  logic                            have_r;
  logic [SUM_W-1:0]                best_r;
  logic [CLASS_W-1:0]              best_cls_r;

  logic                            out_load;
  logic                            out_found_nxt;
  logic [CLASS_W-1:0]              out_class_nxt;
  logic [DIST_W-1:0]               out_dist_nxt;
  logic                            out_valid_r;
  logic                            out_found_r;
  logic [CLASS_W-1:0]              out_class_r;
  logic [DIST_W-1:0]               out_dist_r;
  logic                            out_drop_r;

  // A dimension count of zero behaves as one, anything above the maximum as the maximum.
  always_comb begin
    if (dims_r == '0) begin
      dims_eff = CFG_W'(1);
    end else if (dims_r > CFG_W'(MAX_DIMS)) begin
      dims_eff = CFG_W'(MAX_DIMS);
    end else begin
      dims_eff = dims_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= DIMS_RESET;
    end else if (cfg_we) begin
      dims_r <= cfg_wdata;
    end
  end

  assign pipe_busy = v_rd_r || v_mag_r || v_sq_r || v_sum_r;

  always_comb begin
    state_nxt     = state_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    issue_nxt     = issue_r;
    rd_en         = 1'b0;
    query_start   = 1'b0;
    sqrt_start    = 1'b0;
    out_load      = 1'b0;
    out_found_nxt = 1'b0;
    out_class_nxt = '0;
    out_dist_nxt  = '0;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_item.kind)
            KIND_LOAD: begin
              if (count_r == CNT_W'(MAX_SAMPLES)) begin
                ovf_nxt = 1'b1;
              end else begin
                mem_we    = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            KIND_CLEAR: begin
              count_nxt = '0;
              ovf_nxt   = 1'b0;
            end
            KIND_QUERY: begin
              if (count_r == '0) begin
                out_load = 1'b1;
              end else begin
                query_start = 1'b1;
                issue_nxt   = '0;
                state_nxt   = BK_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      BK_SCAN: begin
        if (issue_r != count_r) begin
          rd_en     = 1'b1;
          issue_nxt = issue_r + 1'b1;
        end else if (!pipe_busy) begin
          sqrt_start = 1'b1;
          state_nxt  = BK_SQRT;
        end
      end
      BK_SQRT: begin
        if (sqrt_done) begin
          out_load      = 1'b1;
          out_found_nxt = 1'b1;
          out_class_nxt = best_cls_r;
          out_dist_nxt  = sqrt_root;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      count_r <= '0;
      ovf_r   <= 1'b0;
      issue_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      issue_r <= issue_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[IDX_W-1:0]] <= {q_item.class_id, q_item.features};
    end
    if (rd_en) begin
      rd_data_r <= mem[issue_r[IDX_W-1:0]];
    end
    if (query_start) begin
      qf_r <= q_item.features;
    end
  end

  // Scan pipeline: read, difference magnitude, square, sum, compare.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_rd_r  <= 1'b0;
      v_mag_r <= 1'b0;
      v_sq_r  <= 1'b0;
      v_sum_r <= 1'b0;
    end else begin
      v_rd_r  <= rd_en;
      v_mag_r <= v_rd_r;
      v_sq_r  <= v_mag_r;
      v_sum_r <= v_sq_r;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [FEAT_W:0] diff;
    for (int d = 0; d < NUM_FEAT; d++) begin
      diff = $signed({qf_r[d][FEAT_W-1], qf_r[d]})
           - $signed({rd_data_r[d*FEAT_W+FEAT_W-1], rd_data_r[d*FEAT_W +: FEAT_W]});
      if (d >= int'(dims_eff)) begin
        mag_r[d] <= '0;
      end else if (diff[FEAT_W]) begin
        mag_r[d] <= MAG_W'(-diff);
      end else begin
        mag_r[d] <= MAG_W'(diff);
      end
    end
    cls_mag_r <= rd_data_r[MEM_W-1 -: CLASS_W];
    for (int d = 0; d < NUM_FEAT; d++) begin
      sq_r[d] <= mag_r[d] * mag_r[d];
    end
    cls_sq_r  <= cls_mag_r;
    sum_r     <= (SUM_W'(sq_r[0]) + SUM_W'(sq_r[1])) + (SUM_W'(sq_r[2]) + SUM_W'(sq_r[3]));
    cls_sum_r <= cls_sq_r;
  end

  // Only a strictly smaller distance replaces the best, so the earliest sample wins ties.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (query_start) begin
      have_r <= 1'b0;
    end else if (v_sum_r && (!have_r || sum_r < best_r)) begin
      have_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (v_sum_r && (!have_r || sum_r < best_r)) begin
      best_r     <= sum_r;
      best_cls_r <= cls_sum_r;
    end
  end

  nnc_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (best_r),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found_r <= out_found_nxt;
      out_class_r <= out_class_nxt;
      out_dist_r  <= out_dist_nxt;
      out_drop_r  <= ovf_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_class_out     = out_class_r;
  assign out_distance      = out_dist_r;
  assign out_loads_dropped = out_drop_r;

endmodule

`default_nettype wire

FILE: rtl/nearest_neighbour_classifier.sv
// Top level of the one-nearest-neighbour classifier: front queue and back end.
// Depends on nnc_pkg, nnc_front and nnc_back.
// A transaction of a known kind enters a two-entry queue and is dequeued the cycle after
// acceptance when the back end is idle. Load and clear complete in the cycle of their dequeue;
// a query on N stored samples scans them (one sample read per cycle, a four-stage distance
// pipeline, a 17-step square root) before its result is taken; on an empty store, the
// result is taken in the cycle after dequeue. The receiver cannot stall. Synchronous reset
// empties the store and the queue and sets the dimension count to 2.
`default_nettype none

module nearest_neighbour_classifier (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [nnc_pkg::KIND_W-1:0]    in_kind,
  input  wire logic signed [nnc_pkg::FEAT_W-1:0] in_feature_0,
  input  wire logic signed [nnc_pkg::FEAT_W-1:0] in_feature_1,
  input  wire logic signed [nnc_pkg::FEAT_W-1:0] in_feature_2,
  input  wire logic signed [nnc_pkg::FEAT_W-1:0] in_feature_3,
  input  wire logic [nnc_pkg::CLASS_W-1:0]   in_class_in,
  input  wire logic                          cfg_we,
  input  wire logic [nnc_pkg::CFG_W-1:0]     cfg_wdata,
  output logic                               out_valid,
  output logic                               out_found,
  output logic [nnc_pkg::CLASS_W-1:0]        out_class_out,
  output logic [nnc_pkg::DIST_W-1:0]         out_distance,
  output logic                               out_loads_dropped
);
  import nnc_pkg::*;

  item_t in_item;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  always_comb begin
    in_item.kind        = kind_t'(in_kind);
    in_item.features[0] = in_feature_0;
    in_item.features[1] = in_feature_1;
    in_item.features[2] = in_feature_2;
    in_item.features[3] = in_feature_3;
    in_item.class_id    = in_class_in;
  end

  nnc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_item     (in_item),
    .in_kind_raw (in_kind),
    .busy        (busy),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  nnc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_found         (out_found),
    .out_class_out     (out_class_out),
    .out_distance      (out_distance),
    .out_loads_dropped (out_loads_dropped)
  );

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the nearest-neighbour classifier: a queue-fed driver, a
// result monitor and an in-bench predictor of the sample store and nearest-match search.
// Depends on nnc_pkg and the nearest_neighbour_classifier RTL only.

module testbench;
  import nnc_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES     = 200;
  localparam int RANDOM_PER_PHASE = 160;
  localparam int NUM_PHASES       = 9;

  typedef struct packed {
    logic [KIND_W-1:0]               kind;
    logic [NUM_FEAT-1:0][FEAT_W-1:0] feat;
    logic [CLASS_W-1:0]              label;
  } request_t;

  typedef struct packed {
    logic               found;
    logic [CLASS_W-1:0] label;
    logic [DIST_W-1:0]  distance;
    logic               dropped;
  } answer_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [KIND_W-1:0]         in_kind = '0;
  logic signed [FEAT_W-1:0]  in_feature_0 = '0;
  logic signed [FEAT_W-1:0]  in_feature_1 = '0;
  logic signed [FEAT_W-1:0]  in_feature_2 = '0;
  logic signed [FEAT_W-1:0]  in_feature_3 = '0;
  logic [CLASS_W-1:0]        in_class_in = '0;
  logic                      cfg_we = 1'b0;
  logic [CFG_W-1:0]          cfg_wdata = '0;
  logic                      out_valid;
  logic                      out_found;
  logic [CLASS_W-1:0]        out_class_out;
  logic [DIST_W-1:0]         out_distance;
  logic                      out_loads_dropped;

  // Predictor state: a copy of the sample store and the dimension setting.
  logic [NUM_FEAT-1:0][FEAT_W-1:0] kept_feat [MAX_SAMPLES];
  logic [CLASS_W-1:0]              kept_label [MAX_SAMPLES];
  int                              kept_count = 0;
  logic                            drop_flag = 1'b0;
  logic [CFG_W-1:0]                dims_setting = DIMS_RESET;

  request_t items_to_send [$];
  answer_t  answers_due [$];
  request_t on_wire;
  bit       ready_for_next;
  int       sender_idle_pct = 0;
  int       fail_count = 0;

  logic [CFG_W-1:0] dims_plan [NUM_PHASES] =
    '{3'd4, 3'd2, 3'd1, 3'd0, 3'd7, 3'd3, 3'd5, 3'd6, 3'd4};
  int idle_plan [NUM_PHASES] = '{0, 72, 0, 38, 72, 0, 38, 72, 0};

  nearest_neighbour_classifier dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_feature_0      (in_feature_0),
    .in_feature_1      (in_feature_1),
    .in_feature_2      (in_feature_2),
    .in_feature_3      (in_feature_3),
    .in_class_in       (in_class_in),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_found         (out_found),
    .out_class_out     (out_class_out),
    .out_distance      (out_distance),
    .out_loads_dropped (out_loads_dropped)
  );

  always #5 clk = ~clk;

  task automatic note_failure(input string msg);
    fail_count++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // Largest r with r*r <= v, built one bit at a time from the top.
  function automatic logic [DIST_W-1:0] floor_root(input longint v);
    logic [DIST_W-1:0] r;
    logic [DIST_W-1:0] cand;
    int b;
    r = '0;
    for (b = DIST_W - 1; b >= 0; b--) begin
      cand = r | (DIST_W'(1) << b);
      if (longint'(cand) * longint'(cand) <= v) r = cand;
    end
    return r;
  endfunction

  // Updates the store copy for one accepted transaction and queues any answer it causes.
  function automatic void track_store(input request_t it);
    int i, d, dims;
    longint diff, sum, best;
    bit have;
    answer_t ans;
    ans = '0;
    if (it.kind == KIND_LOAD) begin
      if (kept_count >= MAX_SAMPLES) begin
        drop_flag = 1'b1;
      end else begin
        kept_feat[kept_count] = it.feat;
        kept_label[kept_count] = it.label;
        kept_count++;
      end
    end else if (it.kind == KIND_CLEAR) begin
      kept_count = 0;
      drop_flag = 1'b0;
    end else if (it.kind == KIND_QUERY) begin
      dims = (dims_setting == 0) ? 1 : (dims_setting > MAX_DIMS ? MAX_DIMS : int'(dims_setting));
      have = 1'b0;
      best = 0;
      for (i = 0; i < kept_count; i++) begin
        sum = 0;
        for (d = 0; d < dims; d++) begin
          diff = longint'($signed(it.feat[d])) - longint'($signed(kept_feat[i][d]));
          sum += diff * diff;
        end
        // Only a strictly smaller distance displaces the earlier sample.
        if (!have || sum < best) begin
          have = 1'b1;
          best = sum;
          ans.label = kept_label[i];
        end
      end
      ans.found = have;
      ans.distance = have ? floor_root(best) : '0;
      ans.dropped = drop_flag;
      answers_due = {answers_due, ans};
    end
  endfunction

  // Driver: start stays high with the same transaction until it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      ready_for_next = !start;
      if (start && !busy) begin
        track_store(on_wire);
        ready_for_next = 1'b1;
      end
      if (ready_for_next) begin
        if (items_to_send.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          on_wire = items_to_send.pop_front();
          start <= 1'b1;
          in_kind <= on_wire.kind;
          in_feature_0 <= on_wire.feat[0];
          in_feature_1 <= on_wire.feat[1];
          in_feature_2 <= on_wire.feat[2];
          in_feature_3 <= on_wire.feat[3];
          in_class_in <= on_wire.label;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result is matched against the oldest outstanding answer.
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid) begin
      if (answers_due.size() == 0) begin
        note_failure("result strobed with no query outstanding");
      end else begin
        want = answers_due.pop_front();
        if (out_found !== want.found)
          note_failure($sformatf("found %0b, expected %0b", out_found, want.found));
        if (out_class_out !== want.label)
          note_failure($sformatf("class %0d, expected %0d", out_class_out, want.label));
        if (out_distance !== want.distance)
          note_failure($sformatf("distance %0d, expected %0d", out_distance, want.distance));
        if (out_loads_dropped !== want.dropped)
          note_failure($sformatf("loads_dropped %0b, expected %0b",
                                 out_loads_dropped, want.dropped));
      end
    end
  end

  function automatic void send(input logic [KIND_W-1:0] kind,
                               input logic [NUM_FEAT*FEAT_W-1:0] feat,
                               input logic [CLASS_W-1:0] label);
    request_t r;
    r.kind = kind;
    r.feat = feat;
    r.label = label;
    items_to_send = {items_to_send, r};
  endfunction

  // Features lean towards the extremes and towards small values near zero.
  function automatic logic [NUM_FEAT*FEAT_W-1:0] pick_features();
    logic [NUM_FEAT-1:0][FEAT_W-1:0] f;
    int d;
    for (d = 0; d < NUM_FEAT; d++) begin
      case ($urandom_range(7))
        0: f[d] = 16'h8000;
        1: f[d] = 16'h7FFF;
        2: f[d] = '0;
        3, 4: f[d] = FEAT_W'($urandom_range(1023)) - 16'd512;
        default: f[d] = FEAT_W'($urandom());
      endcase
    end
    return f;
  endfunction

  task automatic add_directed();
    send(KIND_QUERY, '0, 8'd0);                        // empty store
    send(KIND_UNUSED, {4{16'h1234}}, 8'hAA);           // ignored kind
    send(KIND_LOAD, {4{16'h8000}}, 8'd0);
    send(KIND_QUERY, {4{16'h7FFF}}, 8'd0);             // largest possible distance
    send(KIND_LOAD, {4{16'h7FFF}}, 8'd255);
    send(KIND_QUERY, {4{16'h7FFF}}, 8'd0);             // exact hit
    send(KIND_QUERY, '0, 8'd0);
    send(KIND_QUERY, {4{16'h8000}}, 8'd0);
    send(KIND_CLEAR, '0, 8'd0);
    send(KIND_QUERY, {4{16'h0100}}, 8'd0);             // empty again after a clear
    send(KIND_LOAD, {16'h0, 16'h0, 16'h0, 16'h0100}, 8'd1);
    send(KIND_LOAD, {16'h0, 16'h0, 16'h0, 16'hFF00}, 8'd2);
    send(KIND_QUERY, '0, 8'd0);                        // tie: the first sample wins
    send(KIND_LOAD, {16'h0001, 16'h0, 16'h0, 16'h0}, 8'd3);
    send(KIND_QUERY, '0, 8'd0);
    send(KIND_QUERY, {16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA}, 8'd0);
    send(KIND_LOAD, {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000}, 8'h5A);
    send(KIND_QUERY, {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001}, 8'd0);
  endtask

  // Mostly well-formed runs (clear, loads, queries), some overfilling the store,
  // mixed with short bursts of arbitrary transactions.
  task automatic add_random_traffic(input int target);
    int made, n, j;
    request_t r;
    made = 0;
    while (made < target) begin
      if ($urandom_range(9) == 0) begin
        n = $urandom_range(1, 4);
        for (j = 0; j < n; j++) begin
          r.kind = KIND_W'($urandom_range(3));
          r.feat = pick_features();
          r.label = CLASS_W'($urandom());
          items_to_send = {items_to_send, r};
          if (r.kind != KIND_UNUSED) made++;
        end
      end else begin
        if ($urandom_range(4) != 0) begin
          send(KIND_CLEAR, pick_features(), CLASS_W'($urandom()));
          made++;
        end
        n = ($urandom_range(9) < 2) ? $urandom_range(50, 75) : $urandom_range(1, 10);
        for (j = 0; j < n; j++) send(KIND_LOAD, pick_features(), CLASS_W'($urandom()));
        made += n;
        n = $urandom_range(1, 6);
        for (j = 0; j < n; j++) send(KIND_QUERY, pick_features(), CLASS_W'($urandom()));
        made += n;
      end
    end
  endtask

  // Holds the sender back until every answer is in and the block has settled.
  task automatic drain();
    while (items_to_send.size() != 0 || start || answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    int p;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    for (p = 0; p < NUM_PHASES; p++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_wdata <= dims_plan[p];
      @(posedge clk);
      cfg_we <= 1'b0;
      dims_setting = dims_plan[p];
      sender_idle_pct = idle_plan[p];
      @(negedge clk);
      if (p == 0) add_directed();
      add_random_traffic(RANDOM_PER_PHASE);
      drain();
    end
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: sim.f
rtl/nnc_pkg.sv
rtl/nnc_sqrt.sv
rtl/nnc_front.sv
rtl/nnc_back.sv
rtl/nearest_neighbour_classifier.sv
tb/testbench.sv
